/* sv/cdad_pkg.sv */
package cdad_pkg;

  localparam logic [13:0] YEAR_MAX        = 14'd9999;
  localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
  localparam logic [3:0]  MONTH_JAN       = 4'd1;
  localparam logic [3:0]  MONTH_FEB       = 4'd2;
  localparam logic signed [5:0] OFFSET_LIMIT = 6'sd28;

  // odd divisor check: y * inv(25) mod 2^14 lands in 0..655 exactly for multiples of 25
  localparam logic [13:0] DIV25_INV   = 14'd7209;
  localparam logic [13:0] DIV25_LIMIT = 14'd655;

  function automatic logic is_leap(input logic [13:0] year);
    logic [13:0] prod;
    logic        div25;
    logic        div16;
    begin
      prod  = year * DIV25_INV;
      div25 = (prod <= DIV25_LIMIT);
      div16 = (year[3:0] == 4'd0);
      // divisible by 4, and either not by 100 or also by 400
      is_leap = (year[1:0] == 2'd0) && (!div25 || div16);
    end
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    begin
      case (month) inside
        4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
        MONTH_FEB:               month_len = leap ? 5'd29 : 5'd28;
        default:                 month_len = 5'd31;
      endcase
    end
  endfunction

endpackage

/* sv/calendar_date_add_days.sv */
// Adds a signed day offset (clamped to -28..+28) to a Gregorian date and returns the shifted
// date, crossing at most one month or year boundary; years wrap between 0 and 9999 and raise
// year_wrapped, and an invalid month, day or year raises bad_input with the date passed
// through. Each transaction goes through an input register, one pass of date logic (leap
// test by a single 14-bit constant multiply) and a result register, and a new transaction
// is taken every cycle while the output side keeps up.
module calendar_date_add_days
  import cdad_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [4:0]        cur_day,
  input  logic [3:0]        cur_month,
  input  logic [13:0]       cur_year,
  input  logic signed [5:0] day_offset,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [4:0]        new_day,
  output logic [3:0]        new_month,
  output logic [13:0]       new_year,
  output logic              year_wrapped,
  output logic              bad_input
);

  logic              s1_valid;
  logic [4:0]        s1_day;
  logic [3:0]        s1_month;
  logic [13:0]       s1_year;
  logic signed [5:0] s1_offset;

  logic s2_load;
  logic s1_load;

  assign s2_load  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s2_load;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_day    <= cur_day;
      s1_month  <= cur_month;
      s1_year   <= cur_year;
      s1_offset <= day_offset;
    end
  end

  // date logic
  logic signed [5:0] off_c;
  logic              leap;
  logic [3:0]        prev_month;
  logic [4:0]        len_cur;
  logic [4:0]        len_prev;
  logic              bad;
  logic signed [6:0] sum;
  logic [6:0]        sum_back;
  logic [6:0]        sum_fwd;
  logic [4:0]        day_next;
  logic [3:0]        month_next;
  logic [13:0]       year_next;
  logic              wrapped_next;

  always_comb begin
    if (s1_offset < -OFFSET_LIMIT) begin
      off_c = -OFFSET_LIMIT;
    end else if (s1_offset > OFFSET_LIMIT) begin
      off_c = OFFSET_LIMIT;
    end else begin
      off_c = s1_offset;
    end

    leap       = is_leap(s1_year);
    prev_month = (s1_month == MONTH_JAN) ? MONTHS_PER_YEAR : s1_month - 4'd1;
    len_cur    = month_len(s1_month, leap);
    len_prev   = month_len(prev_month, leap);

    bad = (s1_month == 4'd0) || (s1_month > MONTHS_PER_YEAR) || (s1_year > YEAR_MAX) ||
          (s1_day == 5'd0) || (s1_day > len_cur);

    sum      = $signed({2'b00, s1_day}) + $signed({off_c[5], off_c});
    sum_back = sum + {2'b00, len_prev};
    sum_fwd  = sum - {2'b00, len_cur};

    day_next     = s1_day;
    month_next   = s1_month;
    year_next    = s1_year;
    wrapped_next = 1'b0;

    if (!bad) begin
      if (off_c < 0) begin
        if (sum >= 7'sd1) begin
          day_next = sum[4:0];
        end else begin
          day_next   = sum_back[4:0];
          month_next = prev_month;
          if (s1_month == MONTH_JAN) begin
            if (s1_year == 14'd0) begin
              year_next    = YEAR_MAX;
              wrapped_next = 1'b1;
            end else begin
              year_next = s1_year - 14'd1;
            end
          end
        end
      end else begin
        if (sum <= $signed({2'b00, len_cur})) begin
          day_next = sum[4:0];
        end else begin
          day_next = sum_fwd[4:0];
          if (s1_month != MONTHS_PER_YEAR) begin
            month_next = s1_month + 4'd1;
          end else begin
            month_next = MONTH_JAN;
            if (s1_year >= YEAR_MAX) begin
              year_next    = 14'd0;
              wrapped_next = 1'b1;
            end else begin
              year_next = s1_year + 14'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      new_day      <= day_next;
      new_month    <= month_next;
      new_year     <= year_next;
      year_wrapped <= wrapped_next;
      bad_input    <= bad;
    end
  end

  a_bad_no_wrap: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_input |-> !year_wrapped)
    else $error("wrap flag raised on an invalid date");

  a_wrap_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && year_wrapped |->
      (new_year == 14'd0 && new_month == MONTH_JAN) ||
      (new_year == YEAR_MAX && new_month == MONTHS_PER_YEAR))
    else $error("year wrap landed on the wrong month or year");

  a_good_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_input |->
      new_day != 5'd0 && new_month != 4'd0 && new_month <= MONTHS_PER_YEAR &&
      new_year <= YEAR_MAX)
    else $error("valid date produced an out of range result");

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with the pipeline free");

endmodule

/* verif/tb_calendar_date_add_days.sv */
`timescale 1ns / 1ps

module tb_calendar_date_add_days;
  import cdad_pkg::*;

  localparam int RANDOM_ITEMS = 425;
  localparam int QUIET_TAIL   = 40;
  localparam int LONG_HOLD    = 64;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [5:0]  offset;
  } date_req_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        wrapped;
    logic        bad;
  } date_res_t;

  typedef struct packed {
    date_req_t req;
    logic      known;
    date_res_t res;
  } date_row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [4:0]        cur_day;
  logic [3:0]        cur_month;
  logic [13:0]       cur_year;
  logic signed [5:0] day_offset;
  logic              out_valid;
  logic              out_stall;
  logic [4:0]        new_day;
  logic [3:0]        new_month;
  logic [13:0]       new_year;
  logic              year_wrapped;
  logic              bad_input;

  date_row_t date_rows[$];
  date_res_t expected_dates[$];
  date_res_t next_date;
  int        fail_cnt;
  bit        quiet;
  bit        hold_req;

  calendar_date_add_days dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cur_day      (cur_day),
    .cur_month    (cur_month),
    .cur_year     (cur_year),
    .day_offset   (day_offset),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .new_day      (new_day),
    .new_month    (new_month),
    .new_year     (new_year),
    .year_wrapped (year_wrapped),
    .bad_input    (bad_input)
  );

  function automatic int days_in(input int m, input int y);
    bit leap;
    begin
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      case (m)
        4, 6, 9, 11: days_in = 30;
        int'(MONTH_FEB): days_in = leap ? 29 : 28;
        default: days_in = 31;
      endcase
    end
  endfunction

  function automatic date_res_t shift_date(input date_req_t rq);
    int        d, m, y, o, s, len, lim, ymax, mpy;
    date_res_t r;
    begin
      d    = int'(rq.day);
      m    = int'(rq.month);
      y    = int'(rq.year);
      o    = int'($signed(rq.offset));
      lim  = int'(OFFSET_LIMIT);
      ymax = int'(YEAR_MAX);
      mpy  = int'(MONTHS_PER_YEAR);
      r    = '0;
      if (o < -lim) o = -lim;
      if (o > lim) o = lim;
      if (m < 1 || m > mpy || y > ymax || d < 1 || d > days_in(m, y)) begin
        r.bad = 1'b1;
      end else begin
        s = d + o;
        if (o < 0) begin
          if (s >= 1) begin
            d = s;
          end else if (m != int'(MONTH_JAN)) begin
            m = m - 1;
            d = s + days_in(m, y);
          end else begin
            // back over new year: december always has 31 days
            d = s + 31;
            m = mpy;
            if (y == 0) begin
              y = ymax;
              r.wrapped = 1'b1;
            end else begin
              y = y - 1;
            end
          end
        end else begin
          len = days_in(m, y);
          if (s <= len) begin
            d = s;
          end else begin
            d = s - len;
            if (m != mpy) begin
              m = m + 1;
            end else begin
              m = int'(MONTH_JAN);
              if (y >= ymax) begin
                y = 0;
                r.wrapped = 1'b1;
              end else begin
                y = y + 1;
              end
            end
          end
        end
      end
      r.day   = 5'(d);
      r.month = 4'(m);
      r.year  = 14'(y);
      shift_date = r;
    end
  endfunction

  task automatic add_row(input logic [4:0] d, input logic [3:0] m, input logic [13:0] y,
                         input logic [5:0] o, input int known, input logic [4:0] ed,
                         input logic [3:0] em, input logic [13:0] ey, input int ew,
                         input int eb);
    date_row_t row;
    begin
      row.req   = '{d, m, y, o};
      row.known = 1'(known);
      row.res   = '{ed, em, ey, 1'(ew), 1'(eb)};
      date_rows.push_back(row);
    end
  endtask

  // present one transaction and hold it until the block takes it
  task automatic offer(input date_req_t rq, input date_res_t want);
    int gap;
    begin
      gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
      @(negedge clk);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid   = 1'b1;
      cur_day    = rq.day;
      cur_month  = rq.month;
      cur_year   = rq.year;
      day_offset = rq.offset;
      next_date  = want;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver side: short random stalls, one long hold-off on request
  initial begin
    int  stall_left;
    bit  hold_taken;
    stall_left = 0;
    hold_taken = 1'b0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      out_stall = (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // acceptance and result checking
  always @(posedge clk) begin
    date_res_t got;
    date_res_t want;
    if (!rst) begin
      if (in_valid && !in_stall) expected_dates.push_back(next_date);
      if (out_valid && !out_stall) begin
        got = {new_day, new_month, new_year, year_wrapped, bad_input};
        if (expected_dates.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected result %0d/%0d/%0d wrap %0b bad %0b", got.day, got.month,
                     got.year, got.wrapped, got.bad);
        end else begin
          want = expected_dates.pop_front();
          if (got.day !== want.day || got.month !== want.month || got.year !== want.year ||
              got.wrapped !== want.wrapped || got.bad !== want.bad) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("exp %0d/%0d/%0d wrap %0b bad %0b, got %0d/%0d/%0d wrap %0b bad %0b",
                       want.day, want.month, want.year, want.wrapped, want.bad,
                       got.day, got.month, got.year, got.wrapped, got.bad);
          end
        end
      end
    end
  end

  initial begin
    int        i, sel, m, y, len, o, wait_cnt;
    date_req_t rq;
    date_row_t row;
    fail_cnt   = 0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    cur_day    = '0;
    cur_month  = '0;
    cur_year   = '0;
    day_offset = '0;
    next_date  = '0;

    // day, month, year, offset, typed?, expected day, month, year, wrap, bad
    add_row(5'd1, 4'd1, 14'd2000, 6'sd0, 1, 5'd1, 4'd1, 14'd2000, 0, 0);
    add_row(5'd31, 4'd12, 14'd9999, 6'sd1, 1, 5'd1, 4'd1, 14'd0, 1, 0);
    add_row(5'd1, 4'd1, 14'd0, -6'sd1, 1, 5'd31, 4'd12, 14'd9999, 1, 0);
    add_row(5'd31, 4'd12, 14'd9999, 6'sd28, 1, 5'd28, 4'd1, 14'd0, 1, 0);
    add_row(5'd1, 4'd1, 14'd0, -6'sd28, 1, 5'd4, 4'd12, 14'd9999, 1, 0);
    add_row(5'd5, 4'd0, 14'd2020, 6'sd3, 1, 5'd5, 4'd0, 14'd2020, 0, 1);
    add_row(5'd10, 4'd13, 14'd2020, -6'sd3, 1, 5'd10, 4'd13, 14'd2020, 0, 1);
    add_row(5'd31, 4'd15, 14'd16383, -6'sd32, 1, 5'd31, 4'd15, 14'd16383, 0, 1);
    add_row(5'd0, 4'd6, 14'd1999, 6'sd5, 1, 5'd0, 4'd6, 14'd1999, 0, 1);
    add_row(5'd31, 4'd4, 14'd1999, 6'sd1, 1, 5'd31, 4'd4, 14'd1999, 0, 1);
    add_row(5'd29, 4'd2, 14'd1900, 6'sd1, 1, 5'd29, 4'd2, 14'd1900, 0, 1);
    add_row(5'd1, 4'd1, 14'd10000, 6'sd1, 1, 5'd1, 4'd1, 14'd10000, 0, 1);
    add_row(5'd1, 4'd1, 14'd2001, 6'sd31, 1, 5'd29, 4'd1, 14'd2001, 0, 0);
    add_row(5'd29, 4'd2, 14'd2000, 6'sd1, 0, '0, '0, '0, 0, 0);
    add_row(5'd29, 4'd2, 14'd2024, -6'sd29, 0, '0, '0, '0, 0, 0);
    add_row(5'd15, 4'd3, 14'd2001, -6'sd32, 0, '0, '0, '0, 0, 0);
    add_row(5'd28, 4'd2, 14'd2100, 6'sd1, 0, '0, '0, '0, 0, 0);
    add_row(5'd28, 4'd2, 14'd2400, 6'sd1, 0, '0, '0, '0, 0, 0);
    add_row(5'd1, 4'd3, 14'd1900, -6'sd1, 0, '0, '0, '0, 0, 0);
    add_row(5'd1, 4'd3, 14'd2000, -6'sd1, 0, '0, '0, '0, 0, 0);
    add_row(5'd31, 4'd12, 14'd2023, 6'sd1, 0, '0, '0, '0, 0, 0);
    add_row(5'd1, 4'd1, 14'd2024, -6'sd1, 0, '0, '0, '0, 0, 0);
    add_row(5'd30, 4'd11, 14'd9999, 6'sd28, 0, '0, '0, '0, 0, 0);
    add_row(5'd31, 4'd1, 14'd5000, -6'sd28, 0, '0, '0, '0, 0, 0);
    add_row(5'd15, 4'd6, 14'd1234, 6'sd28, 0, '0, '0, '0, 0, 0);

    repeat (2) @(negedge clk);
    rst = 1'b0;

    foreach (date_rows[k]) begin
      row = date_rows[k];
      offer(row.req, row.known ? row.res : shift_date(row.req));
    end

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      if (i == 150) hold_req = 1'b1;
      if (i == 300) begin
        // let the pipeline run dry before carrying on
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_dates.size() != 0) @(negedge clk);
      end
      sel = $urandom_range(0, 99);
      if (sel < 90) begin
        case ($urandom_range(0, 3))
          0: y = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                      : $urandom_range(int'(YEAR_MAX) - 3, int'(YEAR_MAX));
          1: y = 100 * $urandom_range(0, 99);
          2: y = 4 * $urandom_range(0, 2499);
          default: y = $urandom_range(0, int'(YEAR_MAX));
        endcase
        m   = $urandom_range(0, 2) == 0 ? ($urandom_range(0, 1) ? 2 : 12) : $urandom_range(1, 12);
        len = days_in(m, y);
        rq.year  = 14'(y);
        rq.month = 4'(m);
        if ($urandom_range(0, 1))
          rq.day = 5'($urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(len - 2, len));
        else
          rq.day = 5'($urandom_range(1, len));
        if (sel < 80) begin
          o = $urandom_range(0, 56);
          o = o - 28;
        end else begin
          // offsets outside the clamp range
          o = $urandom_range(29, 32);
          if ($urandom_range(0, 1)) o = -o;
          else if (o == 32) o = 31;
        end
        rq.offset = 6'(o);
      end else begin
        rq.day    = 5'($urandom);
        rq.month  = 4'($urandom);
        rq.year   = 14'($urandom);
        rq.offset = 6'($urandom);
      end
      offer(rq, shift_date(rq));
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait_cnt = 0;
    while (expected_dates.size() != 0 && wait_cnt < 2000) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (8) @(negedge clk);
    fail_cnt += expected_dates.size();

    if (fail_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
